FILE: hw/rtl/itfb_pkg.sv
// Shared types, constants and helper functions of the IMU telemetry frame builder.
package itfb_pkg;

    // Payload store geometry
    localparam int PAYLOAD_BYTES = 21;
    localparam int PL_AW         = $clog2(PAYLOAD_BYTES);
    localparam int PL_CW         = $clog2(PAYLOAD_BYTES + 2);
    localparam int NUM_WORDS     = 10;

    // Frame framing bytes
    localparam logic [7:0] SYNC_0   = 8'hA5;
    localparam logic [7:0] SYNC_1   = 8'h5A;
    localparam logic [7:0] TAIL_B   = 8'hAA;
    localparam logic [15:0] SM_BIAS = 16'h8000;

    // Record kind codes in header bits 6:5
    localparam logic [1:0] KIND_EULER = 2'd1;
    localparam logic [1:0] KIND_QUAT  = 2'd2;

    // Payload byte counts per layout
    localparam logic [PL_CW-1:0] LEN_EULER     = PL_CW'(9);
    localparam logic [PL_CW-1:0] LEN_EULER_POS = PL_CW'(15);
    localparam logic [PL_CW-1:0] LEN_QUAT      = PL_CW'(11);
    localparam logic [PL_CW-1:0] LEN_QUAT_POS  = PL_CW'(17);
    localparam logic [PL_CW-1:0] LEN_RAW       = PL_CW'(21);

    // Configuration register indexes
    localparam logic REG_NODE_ADDR = 1'b0;
    localparam logic REG_WEIGHT    = 1'b1;

    typedef enum logic [1:0] {
        CMD_EULER = 2'd0,
        CMD_QUAT  = 2'd1,
        CMD_RAW   = 2'd2,
        CMD_POLL  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_HDR0,
        S_HDR1,
        S_LEN,
        S_DATA,
        S_CHK,
        S_TAIL
    } t_state;

    // Sign-magnitude form of a two's complement word; -32768 wraps to zero
    function automatic logic [15:0] sign_mag(input logic [15:0] w);
        logic [15:0] r;
        begin
            if (w[15]) begin
                r = SM_BIAS + (~w + 16'd1);
            end else begin
                r = w;
            end
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/itfb_ram.sv
// Generic single-port-write, registered-read RAM.
module itfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 21
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/imu_telemetry_frame_builder.sv
// Top level of the IMU telemetry frame builder: load sequencer, poll framer, APB registers.
//
// Usage:
//   Requests come on the command channel: i_cmd and its fields are taken at a rising edge
//   with start high and busy low. A load (Euler, quaternion or raw) packs the record into
//   payload bytes and writes them into the payload RAM, one byte per cycle, so busy stays
//   high until every payload byte (9 to 21 of them) is written; a load sends nothing.
//   A poll whose low byte equals the node address sends one frame: A5 5A LEN payload CHK AA,
//   one byte per cycle on o_frame_byte with o_valid high and o_last on the AA byte.
//   The first byte appears the cycle after the poll is taken; a frame of n payload
//   bytes is n + 5 bytes long, paced by the single RAM read port, with busy high for all
//   of them. A poll that does not match is taken and dropped; busy stays low.
//   The receiver cannot hold results off: each byte is valid for exactly one cycle.
//   Registers sit on the APB port: node address at 0x0, weightless_flag at 0x4; write them
//   only while busy is low.
//   Reset (synchronous, active low) clears the registers, the stored count and the
//   sequencer; before any load a poll sends A5 5A 02 02 AA. RAM contents are not
//   cleared since only bytes written by the last load are ever read back.
module imu_telemetry_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic        i_pos_present,
    input  logic signed [15:0] i_value_0,
    input  logic signed [15:0] i_value_1,
    input  logic signed [15:0] i_value_2,
    input  logic signed [15:0] i_value_3,
    input  logic signed [15:0] i_value_4,
    input  logic signed [15:0] i_value_5,
    input  logic signed [15:0] i_value_6,
    input  logic signed [15:0] i_value_7,
    input  logic signed [15:0] i_value_8,
    input  logic signed [15:0] i_value_9,
    // result channel
    output logic        o_valid,
    output logic [7:0]  o_frame_byte,
    output logic        o_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import itfb_pkg::*;

    // registers
    t_state                 r_state, n_state;
    logic [4:0]             r_dev_id;
    logic                   r_flag;
    logic [PL_CW-1:0]       r_count;
    logic [PL_CW-1:0]       r_wlen;
    logic [PL_CW-1:0]       r_idx, n_idx;
    logic [PL_CW-1:0]       r_n;
    logic [7:0]             r_len;
    logic [7:0]             r_sum, n_sum;
    logic [7:0]             r_ld [PAYLOAD_BYTES];

    logic                   accept;
    logic                   poll_hit;
    t_cmd                   cmd;
    logic [15:0]            words [NUM_WORDS];
    logic [7:0]             ld_bytes [PAYLOAD_BYTES];
    logic [7:0]             hdr;
    logic [PL_CW-1:0]       ld_len;
    logic                   ram_we, ram_re;
    logic [PL_AW-1:0]       ram_raddr;
    logic [7:0]             ram_rdata;
    logic                   cfg_wr;

    assign cmd      = t_cmd'(i_cmd);
    assign accept   = start && !busy;
    assign poll_hit = (i_value_0[7:0] == {3'b000, r_dev_id});
    assign busy     = (r_state != S_IDLE);

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id <= '0;
            r_flag   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_NODE_ADDR: r_dev_id <= pwdata[4:0];
                REG_WEIGHT:    r_flag   <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NODE_ADDR: prdata = {27'd0, r_dev_id};
            REG_WEIGHT:    prdata = {31'd0, r_flag};
            default:       prdata = '0;
        endcase
    end

    // record packing: header then big-endian words
    always_comb begin
        words[0] = i_value_0;
        words[1] = i_value_1;
        words[2] = i_value_2;
        words[3] = i_value_3;
        words[4] = i_value_4;
        words[5] = i_value_5;
        words[6] = i_value_6;
        words[7] = i_value_7;
        words[8] = i_value_8;
        words[9] = i_value_9;
        unique case (cmd)
            CMD_EULER: begin
                hdr    = {r_flag, KIND_EULER, r_dev_id};
                ld_len = i_pos_present ? LEN_EULER_POS : LEN_EULER;
            end
            CMD_QUAT: begin
                hdr    = {r_flag, KIND_QUAT, r_dev_id};
                ld_len = i_pos_present ? LEN_QUAT_POS : LEN_QUAT;
            end
            default: begin
                hdr    = {3'b000, r_dev_id};
                ld_len = LEN_RAW;
                for (int i = 0; i < NUM_WORDS - 1; i++) begin
                    words[i] = sign_mag(words[i]);
                end
            end
        endcase
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            ld_bytes[b] = '0;
        end
        ld_bytes[0] = hdr;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (2 * i + 1 < PAYLOAD_BYTES) begin
                ld_bytes[2 * i + 1] = words[i][15:8];
            end
            if (2 * i + 2 < PAYLOAD_BYTES) begin
                ld_bytes[2 * i + 2] = words[i][7:0];
            end
        end
    end

    // load shift line and poll capture
    always_ff @(posedge i_clk) begin
        if (accept && cmd != CMD_POLL) begin
            for (int b = 0; b < PAYLOAD_BYTES; b++) begin
                r_ld[b] <= ld_bytes[b];
            end
            r_wlen <= ld_len;
        end else if (r_state == S_LOAD) begin
            for (int b = 0; b < PAYLOAD_BYTES - 1; b++) begin
                r_ld[b] <= r_ld[b + 1];
            end
            r_ld[PAYLOAD_BYTES - 1] <= '0;
        end
        if (accept && cmd == CMD_POLL) begin
            r_len <= 8'(r_count) + 8'd2;
            r_n   <= (r_count == '0) ? '0 : r_count - PL_CW'(1);
        end
    end

    // stored count: payload bytes plus one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept && cmd != CMD_POLL) begin
            r_count <= ld_len + PL_CW'(1);
        end
    end

    // payload store
    assign ram_we = (r_state == S_LOAD);

    itfb_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx[PL_AW-1:0]),
        .i_wdata (r_ld[0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
        end
    end

    // sequencer next state and frame bytes
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_sum        = r_sum;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        o_valid      = 1'b0;
        o_frame_byte = '0;
        o_last       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    if (cmd != CMD_POLL) begin
                        n_state = S_LOAD;
                    end else if (poll_hit) begin
                        n_state = S_HDR0;
                    end
                end
            end
            S_LOAD: begin
                n_idx = r_idx + PL_CW'(1);
                if (r_idx == r_wlen - PL_CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_HDR0: begin
                o_valid      = 1'b1;
                o_frame_byte = SYNC_0;
                n_state      = S_HDR1;
            end
            S_HDR1: begin
                o_valid      = 1'b1;
                o_frame_byte = SYNC_1;
                n_state      = S_LEN;
            end
            S_LEN: begin
                o_valid      = 1'b1;
                o_frame_byte = r_len;
                n_sum        = r_len;
                n_idx        = '0;
                ram_re       = 1'b1;
                n_state      = (r_n == '0) ? S_CHK : S_DATA;
            end
            S_DATA: begin
                o_valid      = 1'b1;
                o_frame_byte = ram_rdata;
                n_sum        = r_sum + ram_rdata;
                n_idx        = r_idx + PL_CW'(1);
                if (r_idx == r_n - PL_CW'(1)) begin
                    n_state = S_CHK;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = n_idx[PL_AW-1:0];
                end
            end
            S_CHK: begin
                o_valid      = 1'b1;
                o_frame_byte = r_sum;
                n_state      = S_TAIL;
            end
            S_TAIL: begin
                o_valid      = 1'b1;
                o_frame_byte = TAIL_B;
                o_last       = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // checks
    a_last_is_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_valid && o_frame_byte == TAIL_B))
        else $error("last flag without closing byte");

    a_poll_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == CMD_POLL && poll_hit) |=> (o_valid && o_frame_byte == SYNC_0))
        else $error("matching poll did not open a frame");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_valid)
        else $error("result while idle");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd != CMD_POLL) |=> (busy && !o_valid))
        else $error("load not writing the store");

    a_frame_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside a frame");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the IMU telemetry frame builder: directed table, random requests.
module tb;
    import itfb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_SHOWN = 10;
    localparam int RAND_PHASES = 5;
    localparam int RAND_PER_PHASE = 62;
    localparam int DIR_ROWS = 23;

    localparam logic [2:0] ADDR_ID = {REG_NODE_ADDR, 2'b00};
    localparam logic [2:0] ADDR_FLAG = {REG_WEIGHT, 2'b00};

    // Frames typed in by hand: poll before any load, Euler at full scale, raw at -32768
    localparam logic [207:0] EMPTY_FRAME = 208'hA55A0202AA;
    localparam logic [207:0] EULER_MAX_FRAME = 208'hA55A0C207FFF7FFF7FFF7FFF24AA;
    localparam logic [207:0] RAW_MIN_FRAME = {24'hA55A18, 152'h0, 32'h800098AA};

    typedef struct packed {
        t_cmd             cmd;
        logic             pos;
        logic [9:0][15:0] val;
    } t_req;

    typedef struct {
        t_req           rq;
        int             lit_n;  // -1: expected frame comes from the predictor
        logic [207:0]   lit;
    } t_row;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_due;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic        i_pos_present;
    logic signed [15:0] i_value_0, i_value_1, i_value_2, i_value_3, i_value_4;
    logic signed [15:0] i_value_5, i_value_6, i_value_7, i_value_8, i_value_9;
    logic        o_valid;
    logic [7:0]  o_frame_byte;
    logic        o_last;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: stored record and register copies
    logic [7:0]  rec_bytes [PAYLOAD_BYTES];
    logic [4:0]  rec_count;
    logic [4:0]  cfg_id;
    logic        cfg_flag;

    t_due        frame_bytes_due [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    t_row        dir_tab [DIR_ROWS];

    imu_telemetry_frame_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_pos_present (i_pos_present),
        .i_value_0     (i_value_0),
        .i_value_1     (i_value_1),
        .i_value_2     (i_value_2),
        .i_value_3     (i_value_3),
        .i_value_4     (i_value_4),
        .i_value_5     (i_value_5),
        .i_value_6     (i_value_6),
        .i_value_7     (i_value_7),
        .i_value_8     (i_value_8),
        .i_value_9     (i_value_9),
        .o_valid       (o_valid),
        .o_frame_byte  (o_frame_byte),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic flag_bad(input string msg);
        if (mismatch_count < MAX_SHOWN)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic due_byte(input logic [7:0] b, input logic is_last);
        t_due d;
        d.data = b;
        d.last = is_last;
        frame_bytes_due.push_back(d);
    endtask

    function automatic logic [15:0] to_sign_mag(input logic [15:0] w);
        return w[15] ? 16'(16'h8000 + (16'h0000 - w)) : w;
    endfunction

    // Expected frame of a poll, or new stored record of a load
    task automatic predict_request(input t_req rq);
        int n;
        int nw;
        logic [7:0] hdr, len, sum;
        logic [15:0] w;
        if (rq.cmd == CMD_POLL) begin
            if (rq.val[0][7:0] != {3'b000, cfg_id})
                return;
            n = (rec_count > 0) ? int'(rec_count) - 1 : 0;
            if (n > PAYLOAD_BYTES)
                n = PAYLOAD_BYTES;
            len = 8'(rec_count + 8'd2);
            sum = len;
            due_byte(SYNC_0, 1'b0);
            due_byte(SYNC_1, 1'b0);
            due_byte(len, 1'b0);
            for (int i = 0; i < n; i++) begin
                due_byte(rec_bytes[i], 1'b0);
                sum = 8'(sum + rec_bytes[i]);
            end
            due_byte(sum, 1'b0);
            due_byte(TAIL_B, 1'b1);
        end else begin
            case (rq.cmd)
                CMD_EULER: begin
                    hdr = {cfg_flag, KIND_EULER, cfg_id};
                    nw = rq.pos ? 7 : 4;
                end
                CMD_QUAT: begin
                    hdr = {cfg_flag, KIND_QUAT, cfg_id};
                    nw = rq.pos ? 8 : 5;
                end
                default: begin
                    hdr = {3'b000, cfg_id};
                    nw = 10;
                end
            endcase
            rec_bytes[0] = hdr;
            for (int j = 0; j < nw; j++) begin
                // raw sensor words go out sign-magnitude, the chip id as is
                w = (rq.cmd == CMD_RAW && j < 9) ? to_sign_mag(rq.val[j]) : rq.val[j];
                rec_bytes[1 + 2 * j] = w[15:8];
                rec_bytes[2 + 2 * j] = w[7:0];
            end
            rec_count = 5'(2 * nw + 2);
        end
    endtask

    // Present one request and hold it until taken
    task automatic drive_req(input t_req rq, input int lit_n, input logic [207:0] lit);
        start <= 1'b1;
        i_cmd <= rq.cmd;
        i_pos_present <= rq.pos;
        i_value_0 <= rq.val[0];
        i_value_1 <= rq.val[1];
        i_value_2 <= rq.val[2];
        i_value_3 <= rq.val[3];
        i_value_4 <= rq.val[4];
        i_value_5 <= rq.val[5];
        i_value_6 <= rq.val[6];
        i_value_7 <= rq.val[7];
        i_value_8 <= rq.val[8];
        i_value_9 <= rq.val[9];
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (lit_n < 0) begin
            predict_request(rq);
        end else begin
            for (int k = 0; k < lit_n; k++)
                due_byte(lit[(lit_n - 1 - k) * 8 +: 8], k == lit_n - 1);
        end
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off until every expected byte has come
    task automatic drain;
        start <= 1'b0;
        do @(posedge i_clk); while (frame_bytes_due.size() != 0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only with the block idle and nothing pending
    task automatic set_config(input logic [4:0] id, input logic flag);
        drain();
        idle_cycles(SETTLE_CYCLES);
        while (busy)
            @(posedge i_clk);
        apb_write(ADDR_ID, {27'b0, id});
        cfg_id = id;
        apb_write(ADDR_FLAG, {31'b0, flag});
        cfg_flag = flag;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req rq;
        int pick;
        pick = $urandom_range(0, 99);
        rq.cmd = (pick < 20) ? CMD_EULER : (pick < 40) ? CMD_QUAT :
                 (pick < 55) ? CMD_RAW : CMD_POLL;
        rq.pos = 1'($urandom_range(0, 1));
        for (int i = 0; i < 10; i++)
            rq.val[i] = rand_word();
        if (rq.cmd == CMD_POLL) begin
            // mostly addressed polls; some differ only above the five id bits
            if ($urandom_range(0, 3) != 0)
                rq.val[0][7:0] = {3'b000, cfg_id};
            else if ($urandom_range(0, 1) != 0)
                rq.val[0][7:0] = {3'($urandom_range(1, 7)), cfg_id};
        end
        return rq;
    endfunction

    function automatic t_row mk_row(input t_cmd c, input logic p, input logic [15:0] base,
                                    input logic [15:0] step, input int n,
                                    input logic [207:0] lit);
        t_row r;
        r.rq.cmd = c;
        r.rq.pos = p;
        for (int i = 0; i < 10; i++)
            r.rq.val[i] = 16'(base + step * 16'(i));
        r.lit_n = n;
        r.lit = lit;
        return r;
    endfunction

    // Compare each frame byte with the oldest expectation
    always @(posedge i_clk) begin : check_frames
        t_due d;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (frame_bytes_due.size() == 0) begin
                    flag_bad($sformatf("unexpected byte %02h last %0b", o_frame_byte, o_last));
                end else begin
                    d = frame_bytes_due.pop_front();
                    if (o_frame_byte !== d.data || o_last !== d.last)
                        flag_bad($sformatf("exp byte %02h last %0b, got byte %02h last %0b",
                                           d.data, d.last, o_frame_byte, o_last));
                end
            end else if (o_valid !== 1'b0) begin
                flag_bad("o_valid unknown");
            end
        end
    end

    initial begin
        logic [4:0] ph_id;
        logic ph_flag;
        int gap;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= CMD_EULER;
        i_pos_present <= 1'b0;
        {i_value_0, i_value_1, i_value_2, i_value_3, i_value_4} <= '0;
        {i_value_5, i_value_6, i_value_7, i_value_8, i_value_9} <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            rec_bytes[i] = 8'h00;
        rec_count = '0;
        cfg_id = '0;
        cfg_flag = 1'b0;

        // Directed rows, registers at reset values
        dir_tab[0]  = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, 5, EMPTY_FRAME);
        dir_tab[1]  = mk_row(CMD_POLL,  1'b0, 16'h0001, 16'h0000, 0, '0);
        dir_tab[2]  = mk_row(CMD_POLL,  1'b1, 16'hFF00, 16'h0000, 5, EMPTY_FRAME);
        dir_tab[3]  = mk_row(CMD_POLL,  1'b0, 16'h0020, 16'h0000, 0, '0);
        dir_tab[4]  = mk_row(CMD_EULER, 1'b0, 16'h7FFF, 16'h0000, -1, '0);
        dir_tab[5]  = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, 14, EULER_MAX_FRAME);
        dir_tab[6]  = mk_row(CMD_EULER, 1'b1, 16'h8000, 16'h0000, -1, '0);
        dir_tab[7]  = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, -1, '0);
        dir_tab[8]  = mk_row(CMD_QUAT,  1'b0, 16'h8001, 16'h1111, -1, '0);
        dir_tab[9]  = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, -1, '0);
        dir_tab[10] = mk_row(CMD_QUAT,  1'b1, 16'hFFFF, 16'h0000, -1, '0);
        dir_tab[11] = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, -1, '0);
        dir_tab[12] = mk_row(CMD_RAW,   1'b1, 16'h7FFE, 16'h0001, -1, '0);
        dir_tab[13] = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, -1, '0);
        dir_tab[14] = mk_row(CMD_RAW,   1'b0, 16'hFFFE, 16'h0001, -1, '0);
        dir_tab[15] = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, -1, '0);
        dir_tab[16] = mk_row(CMD_RAW,   1'b0, 16'h8000, 16'h0000, -1, '0);
        dir_tab[17] = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, 26, RAW_MIN_FRAME);
        dir_tab[18] = mk_row(CMD_EULER, 1'b0, 16'h0000, 16'h0000, -1, '0);
        dir_tab[19] = mk_row(CMD_POLL,  1'b0, 16'h0005, 16'h0000, 0, '0);
        dir_tab[20] = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, -1, '0);
        dir_tab[21] = mk_row(CMD_QUAT,  1'b1, 16'h1234, 16'h0F0F, -1, '0);
        dir_tab[22] = mk_row(CMD_POLL,  1'b0, 16'h0000, 16'h0000, -1, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            gap = gap_len();
            if (gap > 0)
                idle_cycles(gap);
            drive_req(dir_tab[r].rq, dir_tab[r].lit_n, dir_tab[r].lit);
        end

        // Random phases over register settings, extremes first
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            ph_id = (ph == 0 || ph == 2) ? 5'd31 : (ph == 1) ? 5'd0 : 5'($urandom_range(0, 31));
            ph_flag = (ph <= 1) ? 1'b1 : (ph == 2) ? 1'b0 : 1'($urandom_range(0, 1));
            set_config(ph_id, ph_flag);
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                if (k == RAND_PER_PHASE / 2)
                    drain();
                // one phase runs back to back requests
                gap = (ph == 2) ? 0 : gap_len();
                if (gap > 0)
                    idle_cycles(gap);
                drive_req(rand_req(), -1, '0);
            end
        end

        drain();
        idle_cycles(SETTLE_CYCLES);

        if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
